// ----- hw/rtl/dctf_pkg.sv -----
// Shared types, codes, cosine table and helpers for the DCT-II engine.
package dctf_pkg;

   localparam int Points    = 1024;
   localparam int LogPoints = 10;

   localparam logic [1:0] OpLoad = 2'd0;
   localparam logic [1:0] OpRun  = 2'd1;
   localparam logic [1:0] OpRead = 2'd2;

   localparam logic [1:0] StCoef  = 2'd0;
   localparam logic [1:0] StDone  = 2'd1;
   localparam logic [1:0] StEarly = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [9:0]         position;
      logic signed [31:0] sample;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [9:0]         position_out;
      logic signed [47:0] coefficient;
   } rsp_type;

   typedef struct packed {
      logic signed [47:0] re;
      logic signed [47:0] im;
   } work_word_type;

   typedef logic [31:0] quarter_table_type [0:Points];
   typedef logic [63:0] term_div_type [1:12];

   // pi/2 in Q60
   localparam logic [63:0] PiHalfQ60 = 64'h1921_FB54_442D_1846;
   // (2k-1)*2k for the Taylor terms of cos
   localparam term_div_type TermDiv = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
                                        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

   localparam logic signed [50:0] Sat48Hi = {4'b0000, {47{1'b1}}};
   localparam logic signed [50:0] Sat48Lo = {4'b1111, 47'd0};

   // Quarter-wave Q31 cosine table, evaluated at elaboration
   function automatic quarter_table_type make_quarter();
      quarter_table_type  tab;
      logic [63:0]        q_step;
      logic [63:0]        r_step;
      logic [63:0]        x60;
      logic [63:0]        xa;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      q_step = PiHalfQ60 / Points;
      r_step = PiHalfQ60 % Points;
      for (int j = 0; j <= Points; j++) begin
         x60  = q_step * 64'(j) + (r_step * 64'(j)) / Points;
         xa   = x60 >> 29;
         x2   = (xa * xa) >> 31;
         term = 64'd1 << 31;
         sum  = 64'sd1 <<< 31;
         for (int k = 1; k <= 12; k++) begin
            term = ((term * x2) >> 31) / TermDiv[k];
            if (k[0]) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 64'sd0;
         end
         if (sum > (64'sd1 <<< 31)) begin
            sum = 64'sd1 <<< 31;
         end
         tab[j] = sum[31:0];
      end
      return tab;
   endfunction

   localparam quarter_table_type QuarterTab = make_quarter();

   function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
      logic signed [47:0] r;
      if (v > Sat48Hi) begin
         r = Sat48Hi[47:0];
      end else if (v < Sat48Lo) begin
         r = Sat48Lo[47:0];
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

   function automatic logic [LogPoints-1:0] bit_rev(input logic [LogPoints-1:0] v);
      logic [LogPoints-1:0] r;
      for (int i = 0; i < LogPoints; i++) begin
         r[i] = v[LogPoints-1-i];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/dct_ii_via_real_fft.sv -----
// DCT-II engine (Makhoul reorder, radix-2 FFT, output weighting) on a work memory.
//
//  channel   ports                           handshake
//  request   start, busy, req_item           taken when start && !busy
//  response  rsp_strobe, rsp_item            one cycle per result, no backpressure
//
// A load writes the sample memory and leaves the engine idle; a read is
// answered from the work memory (its read is registered). A run reorders
// the samples, then runs the butterflies and the weighting; each butterfly
// is 2 reads, 4 products through the shared 3-stage multiplier, a sum and
// 2 write-backs through the work memory's one read and one write port.
// Synchronous reset clears control only; memories hold garbage until written.
// The receiver cannot stall: rsp_strobe is high for exactly one cycle.
module dct_ii_via_real_fft (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  dctf_pkg::req_type req_item,
   output logic              busy,
   output logic              rsp_strobe,
   output dctf_pkg::rsp_type rsp_item
);

   localparam int Aw = dctf_pkg::LogPoints;
   localparam int N  = dctf_pkg::Points;

   typedef enum logic [4:0] {
      S_IDLE, S_READ, S_LOAD, S_DRAIN, S_RDB, S_RDT, S_M0, S_M1, S_M2, S_M3,
      S_W1, S_W2, S_SUM, S_WT, S_WB, S_WC, S_FIN
   } state_type;

   // memories
   logic signed [31:0]      sample_mem [0:N-1];
   dctf_pkg::work_word_type work_mem [0:N-1];
   logic signed [31:0]      sample_rd_ff;
   dctf_pkg::work_word_type work_rd_ff;
   logic [31:0]             rom_c_ff, rom_s_ff;
   logic                    rom_neg_ff;

   // sequencer
   state_type         state_ff, state_in;
   logic [Aw-1:0]     itm_ff, itm_in;
   logic [3:0]        stg_ff, stg_in;
   logic              wgt_ff, wgt_in;
   logic              done_ff, done_in;
   logic              ld_pend_ff, ld_pend_in;
   logic [Aw-1:0]     ld_addr_ff, ld_addr_in;
   logic [Aw-1:0]     pos_ff, pos_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   dctf_pkg::rsp_type rsp_item_ff, rsp_item_in;
   dctf_pkg::work_word_type a_ff, a_in, b_ff, b_in;
   logic signed [49:0] tr_ff, tr_in, ti_ff, ti_in;

   // multiplier pipeline
   logic               pa_v_ff, pb_v_ff;
   logic [1:0]         pa_tag_ff, pb_tag_ff;
   logic [47:0]        pa_mag_ff;
   logic [31:0]        pa_w_ff;
   logic               pa_neg_ff, pb_neg_ff;
   logic [63:0]        pb_hi_ff;
   logic [47:0]        pb_lo_ff;
   logic signed [48:0] prod_ff [0:3];

   logic               f_v;
   logic [1:0]         f_tag;
   logic signed [47:0] f_a;
   logic [31:0]        f_w;
   logic               f_wneg;
   logic [49:0]        m_rem;
   logic [48:0]        m_q;

   // addressing
   logic                 accept;
   logic [Aw-2:0]        half_mask, jv, bf;
   logic [Aw-1:0]        top_addr, bot_addr, ld_src;
   logic [Aw:0]          tw_fft, tw, rom_ac, rom_as;
   logic                 rom_neg;
   logic [Aw-1:0]        work_raddr, work_waddr;
   logic                 work_we;
   dctf_pkg::work_word_type work_wdata;

   assign accept     = start && (state_ff == S_IDLE);
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // butterfly indices: insert a zero at bit stg of the butterfly count
   always_comb begin
      bf        = itm_ff[Aw-2:0];
      half_mask = (Aw-1)'((Aw'(1) << stg_ff) - Aw'(1));
      jv        = bf & half_mask;
      top_addr  = {bf & ~half_mask, 1'b0} | {1'b0, jv};
      bot_addr  = top_addr | (Aw'(1) << stg_ff);
      tw_fft    = (Aw+1)'({2'b00, jv} << (4'(Aw + 1) - stg_ff));
      tw        = wgt_ff ? {1'b0, itm_ff} : tw_fft;
      if (tw <= (Aw+1)'(N)) begin
         rom_ac  = tw;
         rom_as  = (Aw+1)'(N) - tw;
         rom_neg = 1'b0;
      end else begin
         rom_ac  = (Aw+1)'((Aw+2)'(2 * N) - {1'b0, tw});
         rom_as  = tw - (Aw+1)'(N);
         rom_neg = 1'b1;
      end
      // even samples forward, odd ones reversed
      ld_src = itm_ff[Aw-1] ? {~itm_ff[Aw-2:0], 1'b1} : {itm_ff[Aw-2:0], 1'b0};
   end

   // work memory port control
   always_comb begin
      work_raddr = top_addr;
      work_we    = 1'b0;
      work_waddr = top_addr;
      work_wdata = '{re: 48'(sample_rd_ff), im: '0};
      case (state_ff)
         S_IDLE: work_raddr = req_item.position;
         S_RDB:  work_raddr = wgt_ff ? itm_ff : bot_addr;
         default: work_raddr = top_addr;
      endcase
      if (ld_pend_ff) begin
         work_we    = 1'b1;
         work_waddr = ld_addr_ff;
      end else if (state_ff == S_WT) begin
         work_we    = 1'b1;
         work_wdata = '{re: dctf_pkg::sat48(51'(a_ff.re) + 51'(tr_ff)),
                        im: dctf_pkg::sat48(51'(a_ff.im) + 51'(ti_ff))};
      end else if (state_ff == S_WB) begin
         work_we    = 1'b1;
         work_waddr = bot_addr;
         work_wdata = '{re: dctf_pkg::sat48(51'(a_ff.re) - 51'(tr_ff)),
                        im: dctf_pkg::sat48(51'(a_ff.im) - 51'(ti_ff))};
      end else if (state_ff == S_WC) begin
         work_we    = 1'b1;
         work_waddr = itm_ff;
         work_wdata = '{re: dctf_pkg::sat48({tr_ff, 1'b0}), im: b_ff.im};
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_item.opcode == dctf_pkg::OpLoad) begin
         sample_mem[req_item.position] <= req_item.sample;
      end
      sample_rd_ff <= sample_mem[ld_src];
   end

   always_ff @(posedge clock) begin
      if (work_we) begin
         work_mem[work_waddr] <= work_wdata;
      end
      work_rd_ff <= work_mem[work_raddr];
   end

   // cosine ROM, two registered read ports
   always_ff @(posedge clock) begin
      rom_c_ff   <= dctf_pkg::QuarterTab[rom_ac];
      rom_s_ff   <= dctf_pkg::QuarterTab[rom_as];
      rom_neg_ff <= rom_neg;
   end

   // product operand select: (b.re,c) (b.im,s) (b.im,c) (b.re,s)
   always_comb begin
      f_v    = 1'b0;
      f_tag  = 2'd0;
      f_a    = b_ff.re;
      f_w    = rom_c_ff;
      f_wneg = rom_neg_ff;
      case (state_ff)
         S_M0: begin
            f_v = 1'b1;
         end
         S_M1: begin
            f_v = 1'b1; f_tag = 2'd1; f_a = b_ff.im; f_w = rom_s_ff; f_wneg = 1'b0;
         end
         S_M2: begin
            f_v = 1'b1; f_tag = 2'd2; f_a = b_ff.im;
         end
         S_M3: begin
            f_v = 1'b1; f_tag = 2'd3; f_w = rom_s_ff; f_wneg = 1'b0;
         end
         default: f_v = 1'b0;
      endcase
      m_rem = 50'({pb_hi_ff[14:0], 16'd0}) + 50'(pb_lo_ff) + (50'd1 << 30);
      m_q   = pb_hi_ff[63:15] + 49'(m_rem[49:31]);
   end

   // rounded product a*w/2^31: magnitude, split multiply, round and sign
   always_ff @(posedge clock) begin
      if (reset) begin
         pa_v_ff <= 1'b0;
         pb_v_ff <= 1'b0;
      end else begin
         pa_v_ff <= f_v;
         pb_v_ff <= pa_v_ff;
      end
      pa_tag_ff <= f_tag;
      pa_mag_ff <= f_a[47] ? 48'(-f_a) : 48'(f_a);
      pa_w_ff   <= f_w;
      pa_neg_ff <= f_a[47] ^ f_wneg;
      pb_tag_ff <= pa_tag_ff;
      pb_neg_ff <= pa_neg_ff;
      pb_hi_ff  <= 64'(pa_mag_ff[47:16]) * 64'(pa_w_ff);
      pb_lo_ff  <= 48'(pa_mag_ff[15:0]) * 48'(pa_w_ff);
      if (pb_v_ff) begin
         prod_ff[pb_tag_ff] <= pb_neg_ff ? -$signed(m_q) : $signed(m_q);
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      itm_in        = itm_ff;
      stg_in        = stg_ff;
      wgt_in        = wgt_ff;
      done_in       = done_ff;
      ld_pend_in    = 1'b0;
      ld_addr_in    = dctf_pkg::bit_rev(itm_ff);
      pos_in        = pos_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      tr_in         = tr_ff;
      ti_in         = ti_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pos_in = req_item.position;
               case (req_item.opcode)
                  dctf_pkg::OpRun: begin
                     itm_in   = '0;
                     state_in = S_LOAD;
                  end
                  dctf_pkg::OpRead: state_in = S_READ;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            rsp_strobe_in            = 1'b1;
            rsp_item_in.position_out = pos_ff;
            if (done_ff) begin
               rsp_item_in.status      = dctf_pkg::StCoef;
               rsp_item_in.coefficient = work_rd_ff.re;
            end else begin
               rsp_item_in.status      = dctf_pkg::StEarly;
               rsp_item_in.coefficient = '0;
            end
            state_in = S_IDLE;
         end
         S_LOAD: begin
            ld_pend_in = 1'b1;
            itm_in     = itm_ff + Aw'(1);
            if (itm_ff == Aw'(N - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            itm_in   = '0;
            stg_in   = '0;
            wgt_in   = 1'b0;
            state_in = S_RDB;
         end
         S_RDB: state_in = S_RDT;
         S_RDT: begin
            b_in     = work_rd_ff;
            state_in = S_M0;
         end
         S_M0: begin
            a_in     = work_rd_ff;
            state_in = S_M1;
         end
         S_M1:  state_in = wgt_ff ? S_W1 : S_M2;
         S_M2:  state_in = S_M3;
         S_M3:  state_in = S_W1;
         S_W1:  state_in = S_W2;
         S_W2:  state_in = S_SUM;
         S_SUM: begin
            tr_in    = 50'(prod_ff[0]) + 50'(prod_ff[1]);
            ti_in    = 50'(prod_ff[2]) - 50'(prod_ff[3]);
            state_in = wgt_ff ? S_WC : S_WT;
         end
         S_WT: state_in = S_WB;
         S_WB: begin
            state_in = S_RDB;
            if (itm_ff[Aw-2:0] == (Aw-1)'(N / 2 - 1)) begin
               if (stg_ff == 4'(Aw - 1)) begin
                  wgt_in = 1'b1;
                  itm_in = Aw'(1);
               end else begin
                  stg_in = stg_ff + 4'd1;
                  itm_in = '0;
               end
            end else begin
               itm_in = itm_ff + Aw'(1);
            end
         end
         S_WC: begin
            itm_in   = itm_ff + Aw'(1);
            state_in = (itm_ff == Aw'(N - 1)) ? S_FIN : S_RDB;
         end
         S_FIN: begin
            done_in       = 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_item_in   = '{status: dctf_pkg::StDone, position_out: '0, coefficient: '0};
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         done_ff       <= 1'b0;
         ld_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         done_ff       <= done_in;
         ld_pend_ff    <= ld_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      itm_ff      <= itm_in;
      stg_ff      <= stg_in;
      wgt_ff      <= wgt_in;
      ld_addr_ff  <= ld_addr_in;
      pos_ff      <= pos_in;
      rsp_item_ff <= rsp_item_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      tr_ff       <= tr_in;
      ti_ff       <= ti_in;
   end

endmodule

// ----- hw/rtl/dctf_chk.sv -----
// Port-level checker for the DCT-II engine, bound to the top level.
module dctf_chk (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input dctf_pkg::req_type req_item,
   input dctf_pkg::rsp_type rsp_item
);

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a busy cycle before it");

   a_no_double_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two responses in a row");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.opcode == dctf_pkg::OpLoad) |=> (!busy && !rsp_strobe))
      else $error("sample load occupied the engine");

   a_read_echo: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.opcode == dctf_pkg::OpRead) |=>
         busy ##1 (rsp_strobe && rsp_item.position_out == $past(req_item.position, 2)))
      else $error("read response late or wrong index");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == dctf_pkg::StDone) |->
         (rsp_item.position_out == '0 && rsp_item.coefficient == '0))
      else $error("transform-done response carries data");

endmodule

bind dct_ii_via_real_fft dctf_chk u_dctf_chk (.*);
